// ===== src/cifs_pkg.sv =====
// ---------------------------------------------------------------------------
// cifs_pkg
// Shared types and constants of the CAT info-frame snooper.
// ---------------------------------------------------------------------------
package cifs_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int IDX_W        = $clog2(BUFFER_DEPTH);
  localparam int FREQ_W       = 37;
  localparam int CNT_W        = 16;
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 32;

  typedef logic [IDX_W-1:0] idx_t;

  // action codes of an input word
  localparam logic [1:0] ACT_RADIO = 2'd0;
  localparam logic [1:0] ACT_HOST  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // register indexes of the configuration port
  localparam logic REG_IDLE_WAIT = 1'b0;
  localparam logic REG_REPOLL    = 1'b1;

  // characters
  localparam logic [7:0] CH_TERM = 8'h3B;  // ';'
  localparam logic [7:0] CH_I    = 8'h49;
  localparam logic [7:0] CH_F    = 8'h46;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_R    = 8'h52;
  localparam logic [7:0] CH_X    = 8'h58;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_1    = 8'h31;
  localparam logic [7:0] CH_9    = 8'h39;

  // frame positions
  localparam idx_t POS_HDR1      = IDX_W'(1);
  localparam idx_t POS_FIRST_DIG = IDX_W'(2);
  localparam idx_t POS_LAST_DIG  = IDX_W'(12);
  localparam idx_t POS_MODE      = IDX_W'(29);

  localparam logic [CNT_W-1:0] IDLE_WAIT_RST = CNT_W'(5000);
  localparam logic [CNT_W-1:0] REPOLL_RST    = CNT_W'(2000);

  typedef enum logic [1:0] {
    EMIT_ECHO,
    EMIT_POLL_I,
    EMIT_POLL_F,
    EMIT_POLL_END
  } emit_sel_t;

  typedef struct packed {
    logic      capture;
    logic      dispatch;
    logic      rd_en;
    logic      load;
    emit_sel_t sel;
  } cifs_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       is_term;
    logic       cnt_zero;
    logic       scan_last;
    logic       out_free;
  } cifs_sts_t;

endpackage

// ===== src/cifs_ram.sv =====
// ---------------------------------------------------------------------------
// cifs_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module cifs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/cifs_ctrl.sv =====
// ---------------------------------------------------------------------------
// cifs_ctrl
// Sequencer: accepts a word, dispatches it, scans a finished frame and
// hands the results to the output register.
// ---------------------------------------------------------------------------
module cifs_ctrl
  import cifs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  cifs_sts_t sts,
  output cifs_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_FINISH,
    ST_EMIT_ECHO,
    ST_EMIT_I,
    ST_EMIT_F,
    ST_EMIT_END
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = EMIT_ECHO;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd.dispatch = 1'b1;
        case (sts.action)
          ACT_RADIO: state_nxt = sts.is_term ? ST_SCAN : ST_EMIT_ECHO;
          ACT_HOST:  state_nxt = ST_EMIT_ECHO;
          ACT_TICK:  state_nxt = sts.cnt_zero ? ST_EMIT_I : ST_IDLE;
          default:   state_nxt = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_nxt = ST_EMIT_ECHO;
      end
      ST_EMIT_ECHO: begin
        cmd.sel = EMIT_ECHO;
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT_I: begin
        cmd.sel = EMIT_POLL_I;
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EMIT_F;
        end
      end
      ST_EMIT_F: begin
        cmd.sel = EMIT_POLL_F;
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EMIT_END;
        end
      end
      ST_EMIT_END: begin
        cmd.sel = EMIT_POLL_END;
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/cifs_dp.sv =====
// ---------------------------------------------------------------------------
// cifs_dp
// Datapath: frame buffer, frame parser, poll countdown, transmit flag and
// the output register.
// ---------------------------------------------------------------------------
module cifs_dp
  import cifs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cifs_cmd_t         cmd,
  output cifs_sts_t         sts,
  input  logic [1:0]        in_action,
  input  logic [7:0]        in_data_byte,
  input  logic [CNT_W-1:0]  idle_wait,
  input  logic [CNT_W-1:0]  repoll,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              out_port,
  output logic [FREQ_W-1:0] out_frequency,
  output logic [3:0]        out_mode_code,
  output logic              out_transmitting,
  output logic              out_info_updated,
  output logic              out_last
);

  // captured word
  logic [1:0] act_r;
  logic [7:0] byte_r;

  // architectural state
  idx_t              widx_r;
  logic [7:0]        prev_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [FREQ_W-1:0] freq_r;
  logic [3:0]        mode_r;
  logic              tx_r;
  logic              upd_r;
  logic [BUFFER_DEPTH-1:0] valid_r;

  // scan
  idx_t              pos_r;
  idx_t              rd_pos_r;
  logic              rd_act_r;
  logic              rd_vld_r;
  logic [7:0]        rdata;
  logic [7:0]        rd_byte;
  logic              rd_digit;
  logic [FREQ_W-1:0] facc_r;
  logic              stop_r;
  logic              hdr0_r;
  logic              hdr_ok_r;
  logic [3:0]        mode_dec;

  logic              out_valid_r;
  logic              wr_en;

  assign wr_en = cmd.dispatch && (act_r == ACT_RADIO);

  cifs_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (wr_en),
    .waddr (widx_r),
    .wdata (byte_r),
    .re    (cmd.rd_en),
    .raddr (pos_r),
    .rdata (rdata)
  );

  // never-written entries read as zero
  assign rd_byte  = rd_vld_r ? rdata : 8'h00;
  assign rd_digit = (rd_byte >= CH_0) && (rd_byte <= CH_9);
  assign mode_dec = ((rd_byte >= CH_1) && (rd_byte <= CH_9)) ? rd_byte[3:0] : 4'd0;

  assign sts.action    = act_r;
  assign sts.is_term   = (byte_r == CH_TERM);
  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.scan_last = (pos_r == POS_MODE);
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r  <= in_action;
      byte_r <= in_data_byte;
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widx_r  <= '0;
      prev_r  <= '0;
      cnt_r   <= '0;
      freq_r  <= '0;
      mode_r  <= '0;
      tx_r    <= 1'b0;
      upd_r   <= 1'b0;
      valid_r <= '0;
    end else begin
      if (cmd.dispatch) begin
        upd_r <= 1'b0;
        case (act_r)
          ACT_RADIO: begin
            cnt_r           <= idle_wait;
            valid_r[widx_r] <= 1'b1;
            if (byte_r == CH_TERM || widx_r == IDX_W'(BUFFER_DEPTH - 1)) begin
              widx_r <= '0;
            end else begin
              widx_r <= widx_r + 1'b1;
            end
          end
          ACT_HOST: begin
            cnt_r  <= idle_wait;
            prev_r <= byte_r;
            if (byte_r == CH_X && prev_r == CH_T) begin
              tx_r <= 1'b1;
            end else if (byte_r == CH_X && prev_r == CH_R) begin
              tx_r <= 1'b0;
            end
          end
          ACT_TICK: begin
            cnt_r <= (cnt_r == '0) ? repoll : cnt_r - 1'b1;
          end
          default: ;
        endcase
      end
      // commit the parse once the mode byte arrives
      if (rd_act_r && rd_pos_r == POS_MODE && hdr_ok_r) begin
        freq_r <= facc_r;
        mode_r <= mode_dec;
        upd_r  <= 1'b1;
      end
    end
  end

  // frame scan: positions 0..12, then the mode position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_act_r <= 1'b0;
    end else begin
      rd_act_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dispatch) begin
      pos_r <= '0;
    end else if (cmd.rd_en) begin
      pos_r <= (pos_r == POS_LAST_DIG) ? POS_MODE : pos_r + 1'b1;
    end
    if (cmd.rd_en) begin
      rd_pos_r <= pos_r;
      rd_vld_r <= valid_r[pos_r];
    end
    if (rd_act_r) begin
      if (rd_pos_r == '0) begin
        hdr0_r <= (rd_byte == CH_I);
        facc_r <= '0;
        stop_r <= 1'b0;
      end else if (rd_pos_r == POS_HDR1) begin
        hdr_ok_r <= hdr0_r && (rd_byte == CH_F);
      end else if (rd_pos_r >= POS_FIRST_DIG && rd_pos_r <= POS_LAST_DIG && !stop_r) begin
        if (rd_digit) begin
          facc_r <= (facc_r << 3) + (facc_r << 1) + FREQ_W'(rd_byte[3:0]);
        end else begin
          stop_r <= 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_frequency    <= freq_r;
      out_mode_code    <= mode_r;
      out_transmitting <= tx_r;
      case (cmd.sel)
        EMIT_ECHO: begin
          out_byte         <= byte_r;
          out_port         <= (act_r == ACT_HOST);
          out_info_updated <= upd_r && (act_r == ACT_RADIO);
          out_last         <= 1'b1;
        end
        EMIT_POLL_I: begin
          out_byte         <= CH_I;
          out_port         <= 1'b1;
          out_info_updated <= 1'b0;
          out_last         <= 1'b0;
        end
        EMIT_POLL_F: begin
          out_byte         <= CH_F;
          out_port         <= 1'b1;
          out_info_updated <= 1'b0;
          out_last         <= 1'b0;
        end
        default: begin
          out_byte         <= CH_TERM;
          out_port         <= 1'b1;
          out_info_updated <= 1'b0;
          out_last         <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/cat_info_frame_snooper.sv =====
// ---------------------------------------------------------------------------
// cat_info_frame_snooper
// Watches radio and host CAT traffic, parses IF info frames and polls the
// radio with "IF;" when both links have been silent long enough.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake           words per item
//  in_       input      in_valid/in_stall   one word: action and data byte
//  out_      output     out_valid/out_stall 0, 1 or 3 words, last one flagged
//  apb       config     psel/penable/pready two 16-bit registers at 0x0, 0x4
//
// Every item passes the accept and dispatch states. A radio ';' then
// scans the frame with 14 buffer reads (positions 0..12 and 29) through
// the single read port of the frame buffer before its echo is emitted.
// A polling tick emits three output words; a silent tick or action 3 ends
// after dispatch with no output word.
// Reset (rst_n low at a clock edge) clears the sequencer, the output valid
// flag, the frame buffer's valid bits and the parse results at once;
// there is no clearing pass, unwritten buffer entries read as zero.
// A stalled output holds its word; the sequencer then waits in its emit
// state, and accepts the next input word as soon as the last result of the
// current one is in the output register.
//
module cat_info_frame_snooper
  import cifs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_action,
  input  logic [7:0]        in_data_byte,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              out_port,
  output logic [FREQ_W-1:0] out_frequency,
  output logic [3:0]        out_mode_code,
  output logic              out_transmitting,
  output logic              out_info_updated,
  output logic              out_last,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cifs_cmd_t cmd;
  cifs_sts_t sts;

  logic [CNT_W-1:0] idle_wait_r;
  logic [CNT_W-1:0] repoll_r;
  logic             cfg_wr;
  logic             cfg_sel;

  // register index is the word address; no wait states
  assign pready  = 1'b1;
  assign cfg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_wait_r <= IDLE_WAIT_RST;
      repoll_r    <= REPOLL_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_IDLE_WAIT: idle_wait_r <= pwdata[CNT_W-1:0];
        REG_REPOLL:    repoll_r    <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_IDLE_WAIT: prdata = CFG_DW'(idle_wait_r);
      REG_REPOLL:    prdata = CFG_DW'(repoll_r);
      default:       prdata = '0;
    endcase
  end

  // sequencer: accept, dispatch, scan, emit
  cifs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // buffer, parser, counters and output register
  cifs_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_action),
    .in_data_byte     (in_data_byte),
    .idle_wait        (idle_wait_r),
    .repoll           (repoll_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_port         (out_port),
    .out_frequency    (out_frequency),
    .out_mode_code    (out_mode_code),
    .out_transmitting (out_transmitting),
    .out_info_updated (out_info_updated),
    .out_last         (out_last)
  );

endmodule

// ===== src/cifs_checker.sv =====
// ---------------------------------------------------------------------------
// cifs_checker
// Port-level checks of the CAT info-frame snooper, bound to the top level.
// ---------------------------------------------------------------------------
module cifs_checker
  import cifs_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [7:0]        out_byte,
  input logic              out_port,
  input logic [3:0]        out_mode_code,
  input logic              out_info_updated,
  input logic              out_last
);

  // hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output word changed");

  // one word at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous word in progress");

  // an info update only rides on the radio ';' that closed the frame
  a_update_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_info_updated |-> !out_port && out_last && out_byte == CH_TERM)
    else $error("info update on wrong word");

  // only poll words come in groups
  a_group_is_poll: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_port && (out_byte == CH_I || out_byte == CH_F))
    else $error("non-final word that is not part of a poll");

  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_mode_code <= 4'd9)
    else $error("mode code out of range");

endmodule

bind cat_info_frame_snooper cifs_checker u_cifs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_byte         (out_byte),
  .out_port         (out_port),
  .out_mode_code    (out_mode_code),
  .out_info_updated (out_info_updated),
  .out_last         (out_last)
);
